[hw/rtl/nad_pkg.sv]
`timescale 1ns / 1ps

package nad_pkg;

   // Unity gain in Q1.15 and the constants of the gain mapping.
   localparam int GAIN_ONE  = 32768;
   localparam int GI_BASE   = 9830;    // 0.3 in Q1.15
   localparam int GI_SPAN   = 13107;   // 0.4 in Q1.15
   localparam int GO_BASE   = 13107;   // 0.4 in Q1.15
   localparam int GO_SPAN   = 9830;    // 0.3 in Q1.15
   localparam int ROUND_Q15 = 16384;   // half an LSB before a shift by 15
   localparam int ROUND_Q2  = 2;       // half an LSB before a shift by 2

   // Control of one delay line: an item enters its line stage, an item leaves it.
   typedef struct packed {
      logic load;
      logic retire;
   } line_ctl_type;

endpackage

[hw/rtl/nad_ram.sv]
`timescale 1ns / 1ps

module nad_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/nad_delay_line.sv]
`timescale 1ns / 1ps

module nad_delay_line #(
   parameter int DELAY = 511,
   parameter int WIDTH = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nad_pkg::line_ctl_type ctl,
   input  logic [WIDTH-1:0]     wr_data,
   output logic [WIDTH-1:0]     rd_data
);

   import nad_pkg::*;

   generate
      if (DELAY == 1) begin : g_reg
         // A one-sample delay feeds straight back, so the value leaving the
         // stage is forwarded to the item entering it at the same edge.
         logic [WIDTH-1:0] last_ff;
         logic [WIDTH-1:0] held_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               last_ff <= '0;
            end else if (ctl.retire) begin
               last_ff <= wr_data;
            end
         end

         always_ff @(posedge clock) begin
            if (ctl.load) begin
               held_ff <= ctl.retire ? wr_data : last_ff;
            end
         end

         assign rd_data = held_ff;
      end else begin : g_ram
         localparam int AW = $clog2(DELAY);
         localparam int FW = $clog2(DELAY + 1);

         logic [AW-1:0]    ptr_ff;
         logic [AW-1:0]    addr_ff;
         logic [FW-1:0]    fill_ff;
         logic             valid_ff;
         logic [WIDTH-1:0] ram_q;

         // The entry at the pointer is the oldest one; it is read when an
         // item enters and overwritten at the same address when it leaves.
         always_ff @(posedge clock) begin
            if (reset) begin
               ptr_ff   <= '0;
               fill_ff  <= '0;
               valid_ff <= 1'b0;
            end else if (ctl.load) begin
               ptr_ff   <= (ptr_ff == AW'(DELAY - 1)) ? '0 : ptr_ff + 1'b1;
               valid_ff <= (fill_ff == FW'(DELAY));
               if (fill_ff != FW'(DELAY)) begin
                  fill_ff <= fill_ff + 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (ctl.load) begin
               addr_ff <= ptr_ff;
            end
         end

         nad_ram #(
            .WIDTH (WIDTH),
            .DEPTH (DELAY)
         ) u_ram (
            .clock   (clock),
            .wr_en   (ctl.retire),
            .wr_addr (addr_ff),
            .wr_data (wr_data),
            .rd_en   (ctl.load),
            .rd_addr (ptr_ff),
            .rd_data (ram_q)
         );

         // Entries not yet written since reset read as zero.
         assign rd_data = valid_ff ? ram_q : '0;
      end
   endgenerate

endmodule

[hw/rtl/nested_allpass_diffuser.sv]
`timescale 1ns / 1ps

// Nested allpass diffuser, one audio sample in, one diffused sample out.
// The request channel (req_valid, req_stall, req_sample_in) carries signed
// samples; the response channel (rsp_valid, rsp_stall, rsp_sample_out) returns
// one saturated sample per request, in order. A transfer happens at a rising
// edge with valid high and stall low. The diffusion amount is written through
// csr_wr_en / csr_wr_data while no samples are in flight; the gains derived
// from it are computed and registered at the write.
// The datapath is a ten-stage pipeline whose last register, y9_ff, drives
// rsp_sample_out; one sample per cycle is sustained while nothing stalls.
// The rate is set by the delay line stages: a line reads as a sample
// enters and writes its store value as the sample leaves, and a one-sample
// line forwards that value to the next sample.
// Synchronous reset clears all stage valid bits, the delay line pointers and
// fill counts, and loads the default diffusion amount of zero. The delay
// memories are not swept; a fill count per line makes entries that were not
// written since reset read as zero, so samples are taken right after reset.
// When the receiver stalls, the output holds and stages close up behind it;
// req_stall rises only once all ten stages hold a sample.
module nested_allpass_diffuser #(
   parameter int OUTER_LEN   = 512,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                          csr_wr_en,
   input  logic [15:0]                   csr_wr_data
);

   import nad_pkg::*;

   localparam int SB  = SAMPLE_BITS;
   localparam int NST = 10;

   // Each line delays by its length minus one sample.
   localparam int INNER_DELAY [4] = '{OUTER_LEN / 7 - 1, OUTER_LEN / 11 - 1,
                                      OUTER_LEN / 13 - 1, OUTER_LEN / 17 - 1};
   localparam int OUTER_DELAY = OUTER_LEN - 1;

   localparam logic signed [SB+5:0] SAT_MAX = {{7{1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [SB+5:0] SAT_MIN = {{7{1'b1}}, {(SB-1){1'b0}}};
   localparam logic signed [SB+16:0] HALF_G = (SB+17)'(ROUND_Q15);
   localparam logic signed [SB+19:0] HALF_M = (SB+20)'(ROUND_Q15);
   localparam logic signed [SB+3:0]  HALF_A = (SB+4)'(ROUND_Q2);

   function automatic logic signed [SB-1:0] saturate(input logic signed [SB+5:0] v);
      logic signed [SB+5:0] r;
      r = v;
      if (v > SAT_MAX) begin
         r = SAT_MAX;
      end else if (v < SAT_MIN) begin
         r = SAT_MIN;
      end
      return r[SB-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // Configuration: amount clamped to one, gains derived at write time.
   // ---------------------------------------------------------------------
   logic [15:0] d_ff, d_in;
   logic [15:0] gi_ff, gi_in;
   logic [15:0] go_ff, go_in;
   logic [16:0] dc_ff, dc_in;
   logic [29:0] gi_prod, go_prod;

   always_comb begin
      d_in    = (csr_wr_data > 16'(GAIN_ONE)) ? 16'(GAIN_ONE) : csr_wr_data;
      gi_prod = 30'(GI_SPAN) * 30'(d_in) + 30'(ROUND_Q15);
      go_prod = 30'(GO_SPAN) * 30'(d_in) + 30'(ROUND_Q15);
      gi_in   = 16'(GI_BASE) + 16'(gi_prod >> 15);
      go_in   = 16'(GO_BASE) + 16'(go_prod >> 15);
      dc_in   = 17'(GAIN_ONE) - 17'(d_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff  <= '0;
         gi_ff <= 16'(GI_BASE);
         go_ff <= 16'(GO_BASE);
         dc_ff <= 17'(GAIN_ONE);
      end else if (csr_wr_en) begin
         d_ff  <= d_in;
         gi_ff <= gi_in;
         go_ff <= go_in;
         dc_ff <= dc_in;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control. A stage takes a new sample when it is empty or when
   // the stage after it moves, so bubbles close up under a stall.
   // ---------------------------------------------------------------------
   logic [NST-1:0] valid_ff, valid_in;
   logic [NST-1:0] ready;

   always_comb begin
      ready[NST-1] = !valid_ff[NST-1] || !rsp_stall;
      for (int k = NST - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NST; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NST-1];

   // ---------------------------------------------------------------------
   // Datapath registers, stage by stage.
   // ---------------------------------------------------------------------
   logic signed [SB-1:0]   x0_ff, x1_ff, x2_ff, x3_ff, x4_ff;
   logic signed [SB+16:0]  prod1_ff;
   logic signed [SB:0]     gx2_ff, gx2_in;
   logic signed [SB+1:0]   inner3_ff [4];
   logic signed [SB+1:0]   inner_out [4];
   logic signed [SB+1:0]   avg4_ff, avg4_in;
   logic signed [SB+17:0]  mixa5_ff;
   logic signed [SB+18:0]  mixb5_ff;
   logic signed [SB-1:0]   mix6_ff, mix6_in;
   logic signed [SB+16:0]  prodo7_ff;
   logic signed [SB:0]     gxo8_ff, gxo8_in;
   logic signed [SB-1:0]   y9_ff, y9_in;

   logic signed [SB-1:0]   inner_delayed [4];
   logic signed [SB-1:0]   inner_store [4];
   logic signed [SB+1:0]   inner_sum_w [4];
   logic signed [SB-1:0]   outer_delayed;
   logic signed [SB-1:0]   outer_store;
   logic signed [SB+1:0]   outer_sum_w, outer_diff_w;
   logic signed [SB+16:0]  gx_round, gxo_round;
   logic signed [SB+3:0]   avg_sum;
   logic signed [SB+19:0]  mix_sum;
   logic signed [SB+4:0]   mix_wide;

   always_comb begin
      // Inner gain product, rounded half up.
      gx_round = prod1_ff + HALF_G;
      gx2_in   = gx_round[SB+15:15];

      // Inner allpass: store gx + delayed, emit delayed - gx.
      for (int k = 0; k < 4; k++) begin
         inner_sum_w[k] = {{2{inner_delayed[k][SB-1]}}, inner_delayed[k]}
                          + {gx2_ff[SB], gx2_ff};
         inner_store[k] = saturate({{4{inner_sum_w[k][SB+1]}}, inner_sum_w[k]});
         inner_out[k]   = {{2{inner_delayed[k][SB-1]}}, inner_delayed[k]}
                          - {gx2_ff[SB], gx2_ff};
      end

      // Average of the four inner outputs.
      avg_sum = {{2{inner3_ff[0][SB+1]}}, inner3_ff[0]}
              + {{2{inner3_ff[1][SB+1]}}, inner3_ff[1]}
              + {{2{inner3_ff[2][SB+1]}}, inner3_ff[2]}
              + {{2{inner3_ff[3][SB+1]}}, inner3_ff[3]}
              + HALF_A;
      avg4_in = avg_sum[SB+3:2];

      // Crossfade of dry and diffused signal.
      mix_sum  = {{2{mixa5_ff[SB+17]}}, mixa5_ff} + {mixb5_ff[SB+18], mixb5_ff} + HALF_M;
      mix_wide = mix_sum[SB+19:15];
      mix6_in  = saturate({mix_wide[SB+4], mix_wide});

      // Outer gain product, rounded half up.
      gxo_round = prodo7_ff + HALF_G;
      gxo8_in   = gxo_round[SB+15:15];

      // Outer allpass.
      outer_sum_w  = {{2{outer_delayed[SB-1]}}, outer_delayed} + {gxo8_ff[SB], gxo8_ff};
      outer_store  = saturate({{4{outer_sum_w[SB+1]}}, outer_sum_w});
      outer_diff_w = {{2{outer_delayed[SB-1]}}, outer_delayed} - {gxo8_ff[SB], gxo8_ff};
      y9_in        = saturate({{4{outer_diff_w[SB+1]}}, outer_diff_w});
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         x0_ff <= req_sample_in;
      end
      if (ready[1]) begin
         x1_ff    <= x0_ff;
         prod1_ff <= $signed(x0_ff) * $signed({1'b0, gi_ff});
      end
      if (ready[2]) begin
         x2_ff  <= x1_ff;
         gx2_ff <= gx2_in;
      end
      if (ready[3]) begin
         x3_ff <= x2_ff;
         for (int k = 0; k < 4; k++) begin
            inner3_ff[k] <= inner_out[k];
         end
      end
      if (ready[4]) begin
         x4_ff   <= x3_ff;
         avg4_ff <= avg4_in;
      end
      if (ready[5]) begin
         mixa5_ff <= $signed(x4_ff) * $signed({1'b0, dc_ff});
         mixb5_ff <= $signed(avg4_ff) * $signed({1'b0, d_ff});
      end
      if (ready[6]) begin
         mix6_ff <= mix6_in;
      end
      if (ready[7]) begin
         prodo7_ff <= $signed(mix6_ff) * $signed({1'b0, go_ff});
      end
      if (ready[8]) begin
         gxo8_ff <= gxo8_in;
      end
      if (ready[9]) begin
         y9_ff <= y9_in;
      end
   end

   assign rsp_sample_out = y9_ff;

   // ---------------------------------------------------------------------
   // Delay lines. The inner lines sit in stage two, the outer one in stage
   // eight; each reads when a sample enters and writes when it leaves.
   // ---------------------------------------------------------------------
   line_ctl_type inner_ctl, outer_ctl;

   assign inner_ctl.load   = ready[2] && valid_ff[1];
   assign inner_ctl.retire = valid_ff[2] && ready[3];
   assign outer_ctl.load   = ready[8] && valid_ff[7];
   assign outer_ctl.retire = valid_ff[8] && ready[9];

   generate
      for (genvar k = 0; k < 4; k++) begin : g_inner
         logic [SB-1:0] rd_q;

         nad_delay_line #(
            .DELAY (INNER_DELAY[k]),
            .WIDTH (SB)
         ) u_line (
            .clock   (clock),
            .reset   (reset),
            .ctl     (inner_ctl),
            .wr_data (inner_store[k]),
            .rd_data (rd_q)
         );

         assign inner_delayed[k] = rd_q;
      end
   endgenerate

   logic [SB-1:0] outer_q;

   nad_delay_line #(
      .DELAY (OUTER_DELAY),
      .WIDTH (SB)
   ) u_outer_line (
      .clock   (clock),
      .reset   (reset),
      .ctl     (outer_ctl),
      .wr_data (outer_store),
      .rd_data (outer_q)
   );

   assign outer_delayed = outer_q;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // The input is held off only when every stage is full and the output stalls.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid_ff) && rsp_stall))
      else $error("request stalled while the pipeline has room");

   // The dry and wet crossfade weights always add up to one.
   a_weights_sum_to_one: assert property (@(posedge clock) disable iff (reset)
      (17'(d_ff) + dc_ff) == 17'(GAIN_ONE))
      else $error("crossfade weights out of step");

   // A gain update follows a configuration write and stays in its range.
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (gi_ff >= 16'(GI_BASE)) && (gi_ff <= 16'(GI_BASE + GI_SPAN))
                    && (go_ff >= 16'(GO_BASE)) && (go_ff <= 16'(GO_BASE + GO_SPAN)))
      else $error("derived gain out of range");

endmodule
